[design/fch_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fch_pkg
// Shared types and constants of the chained hash index.
// ----------------------------------------------------------------------------
package fch_pkg;

    localparam int NUM_SLOTS   = 256;
    localparam int MAX_BUCKETS = 64;
    localparam int KEY_BYTES   = 8;

    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int LINK_W   = SLOT_W + 1;
    localparam int BUCKET_W = $clog2(MAX_BUCKETS);
    localparam int KEY_W    = 8 * KEY_BYTES;
    localparam int LEN_W    = 4;
    localparam int BC_W     = 7;

    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(NUM_SLOTS);
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NOP         = 5'd0;
    localparam cmd_t CMD_LOAD        = 5'd1;
    localparam cmd_t CMD_RD_SLOT     = 5'd2;
    localparam cmd_t CMD_HASH_REQ    = 5'd3;
    localparam cmd_t CMD_HASH_STORED = 5'd4;
    localparam cmd_t CMD_HASH_STEP   = 5'd5;
    localparam cmd_t CMD_MOD_START   = 5'd6;
    localparam cmd_t CMD_MOD_STEP    = 5'd7;
    localparam cmd_t CMD_RD_HEAD     = 5'd8;
    localparam cmd_t CMD_LOAD_K      = 5'd9;
    localparam cmd_t CMD_HEAD_WR     = 5'd10;
    localparam cmd_t CMD_RD_K        = 5'd11;
    localparam cmd_t CMD_NEXT_WR     = 5'd12;
    localparam cmd_t CMD_ADV_K       = 5'd13;
    localparam cmd_t CMD_CLEAR_SLOT  = 5'd14;
    localparam cmd_t CMD_INSERT      = 5'd15;
    localparam cmd_t CMD_FOUND       = 5'd16;
    localparam cmd_t CMD_OUT         = 5'd17;

    typedef struct packed {
        logic [1:0] op;
        logic       used_s;
        logic       hash_done;
        logic       mod_done;
        logic       k_is_s;
        logic       k_end;
        logic       steps_end;
        logic       next_is_s;
        logic       match;
        logic       out_free;
    } status_t;

endpackage

[design/fnv_chained_hash_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv_chained_hash_index
// Slot-indexed hash index with FNV-1a bucket hashing and chained buckets.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one request a transfer: opcode in s_tuser, slot, key and
//   key_len in s_tdata. m_* returns exactly one result a request: hit and
//   found_slot. cfg_we/cfg_wdata set bucket_count and empty the index.
// operation:
//   one request at a time. an insert of a free slot or a find loads the
//   request, hashes the key bytes, reduces the hash in the bit-serial
//   modulo unit, reads the bucket head and finishes; a find walks the
//   bucket chain entry by entry before it finishes. an insert of a linked
//   slot or a remove of one first hashes the stored key and walks its
//   chain. a remove of a free slot or an unused opcode skips the hash and
//   goes straight to the result. the next request is taken the cycle the
//   result appears.
// reset:
//   all buckets empty, all slots free, bucket_count 64; no clearing pass.
// stall:
//   a result waits in the output register; the next request is taken
//   meanwhile and holds in its last step until the register is free.
// ----------------------------------------------------------------------------
module fnv_chained_hash_index (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // slot[7:0], key[71:8], key_len[75:72], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // hit[0], found_slot[8:1], zero pad
);

    fch_pkg::cmd_t    cmd;
    fch_pkg::status_t status;

    fch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fch_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_tuser),
        .in_slot   (s_tdata[7:0]),
        .in_key    (s_tdata[71:8]),
        .in_len    (s_tdata[75:72]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[design/fch_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/fch_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fch_datapath
// Hash unit, modulo unit, link and key stores and result register.
// ----------------------------------------------------------------------------
module fch_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fch_pkg::cmd_t            cmd,
    output fch_pkg::status_t         status,
    input  logic                     cfg_we,
    input  logic [fch_pkg::BC_W-1:0] cfg_wdata,
    input  logic [1:0]               in_op,
    input  logic [7:0]               in_slot,
    input  logic [63:0]              in_key,
    input  logic [3:0]               in_len,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata
);

    localparam int SW = fch_pkg::SLOT_W;
    localparam int LW = fch_pkg::LINK_W;
    localparam int BW = fch_pkg::BUCKET_W;
    localparam int KW = fch_pkg::KEY_W;
    localparam int NL = fch_pkg::LEN_W;

    logic [fch_pkg::BC_W-1:0] bc_reg;
    logic [1:0]    op_reg;
    logic [SW-1:0] slot_reg;
    logic [KW-1:0] key_reg;
    logic [NL-1:0] len_reg;
    logic [KW-1:0] hkey_reg;
    logic [NL-1:0] hlen_reg;
    logic [NL-1:0] hcnt_reg;
    logic [31:0]   h_reg;
    logic [31:0]   div_reg;
    logic [6:0]    rem_reg;
    logic [5:0]    mcnt_reg;
    logic [BW-1:0] bucket_reg;
    logic [LW-1:0] k_reg;
    logic [LW-1:0] next_s_reg;
    logic [LW-1:0] steps_reg;
    logic          hit_reg;
    logic [SW-1:0] res_reg;
    logic [fch_pkg::MAX_BUCKETS-1:0] head_vld_reg;
    logic [fch_pkg::NUM_SLOTS-1:0]   used_reg;
    logic          out_vld_reg;
    logic [15:0]   out_data_reg;

    logic [NL-1:0] len_clamp;
    logic [KW-1:0] key_masked;
    logic [6:0]    n_eff;
    logic [6:0]    mod_t;
    logic [31:0]   hx;

    logic          head_we;
    logic [LW-1:0] head_wdata;
    logic [LW-1:0] head_rdata;
    logic          next_we;
    logic [SW-1:0] next_waddr;
    logic [LW-1:0] next_wdata;
    logic [LW-1:0] next_rdata;
    logic [SW-1:0] rd_addr;
    logic          key_we;
    logic [KW+NL-1:0] key_rdata;

    always_comb
    begin
        len_clamp = (in_len > NL'(fch_pkg::KEY_BYTES)) ? NL'(fch_pkg::KEY_BYTES) : in_len;
        for (int i = 0; i < fch_pkg::KEY_BYTES; i++)
        begin
            key_masked[8*i +: 8] = (NL'(i) < len_clamp) ? in_key[8*i +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        if (bc_reg == '0)
            n_eff = 7'd1;
        else if (bc_reg > 7'(fch_pkg::MAX_BUCKETS))
            n_eff = 7'(fch_pkg::MAX_BUCKETS);
        else
            n_eff = bc_reg;
    end

    assign mod_t = {rem_reg[5:0], div_reg[31]};
    assign hx    = h_reg ^ {24'd0, hkey_reg[7:0]};

    assign head_we    = (cmd == fch_pkg::CMD_HEAD_WR) || (cmd == fch_pkg::CMD_INSERT);
    assign head_wdata = (cmd == fch_pkg::CMD_INSERT) ? {1'b0, slot_reg} : next_s_reg;
    assign next_we    = (cmd == fch_pkg::CMD_NEXT_WR) || (cmd == fch_pkg::CMD_INSERT);
    assign next_waddr = (cmd == fch_pkg::CMD_INSERT) ? slot_reg : k_reg[SW-1:0];
    assign next_wdata = (cmd == fch_pkg::CMD_INSERT) ? k_reg : next_s_reg;
    assign rd_addr    = (cmd == fch_pkg::CMD_RD_K) ? k_reg[SW-1:0] : slot_reg;
    assign key_we     = (cmd == fch_pkg::CMD_INSERT);

    fch_ram #(.WIDTH(LW), .DEPTH(fch_pkg::MAX_BUCKETS)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (bucket_reg),
        .wdata (head_wdata),
        .raddr (rem_reg[BW-1:0]),
        .rdata (head_rdata)
    );

    fch_ram #(.WIDTH(LW), .DEPTH(fch_pkg::NUM_SLOTS)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    fch_ram #(.WIDTH(KW + NL), .DEPTH(fch_pkg::NUM_SLOTS)) u_key (
        .clk   (clk),
        .we    (key_we),
        .waddr (slot_reg),
        .wdata ({len_reg, key_reg}),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    // control state: config, valid bits and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg       <= 7'(fch_pkg::MAX_BUCKETS);
            head_vld_reg <= '0;
            used_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && m_tready)
                out_vld_reg <= 1'b0;
            if (cmd == fch_pkg::CMD_OUT)
                out_vld_reg <= 1'b1;
            if (head_we)
                head_vld_reg[bucket_reg] <= 1'b1;
            if (cmd == fch_pkg::CMD_INSERT)
                used_reg[slot_reg] <= 1'b1;
            if (cmd == fch_pkg::CMD_CLEAR_SLOT)
                used_reg[slot_reg] <= 1'b0;
            if (cfg_we)
            begin
                bc_reg       <= cfg_wdata;
                head_vld_reg <= '0;
                used_reg     <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            fch_pkg::CMD_LOAD:
            begin
                op_reg    <= in_op;
                slot_reg  <= in_slot;
                key_reg   <= key_masked;
                len_reg   <= len_clamp;
                hit_reg   <= 1'b0;
                res_reg   <= in_slot;
                steps_reg <= '0;
            end
            fch_pkg::CMD_RD_SLOT:
            begin
                hit_reg <= 1'b1;
            end
            fch_pkg::CMD_HASH_REQ:
            begin
                hkey_reg <= key_reg;
                hlen_reg <= len_reg;
                hcnt_reg <= '0;
                h_reg    <= fch_pkg::FNV_BASIS;
            end
            fch_pkg::CMD_HASH_STORED:
            begin
                hkey_reg   <= key_rdata[KW-1:0];
                hlen_reg   <= key_rdata[KW +: NL];
                hcnt_reg   <= '0;
                h_reg      <= fch_pkg::FNV_BASIS;
                next_s_reg <= next_rdata;
            end
            fch_pkg::CMD_HASH_STEP:
            begin
                h_reg    <= 32'(hx * fch_pkg::FNV_PRIME);
                hkey_reg <= hkey_reg >> 8;
                hcnt_reg <= hcnt_reg + 1'b1;
            end
            fch_pkg::CMD_MOD_START:
            begin
                div_reg  <= h_reg;
                rem_reg  <= '0;
                mcnt_reg <= '0;
            end
            fch_pkg::CMD_MOD_STEP:
            begin
                // restoring division, one quotient bit per cycle
                rem_reg  <= (mod_t >= n_eff) ? mod_t - n_eff : mod_t;
                div_reg  <= div_reg << 1;
                mcnt_reg <= mcnt_reg + 1'b1;
            end
            fch_pkg::CMD_RD_HEAD:
            begin
                bucket_reg <= rem_reg[BW-1:0];
            end
            fch_pkg::CMD_LOAD_K:
            begin
                k_reg <= head_vld_reg[bucket_reg] ? head_rdata : fch_pkg::NO_SLOT;
            end
            fch_pkg::CMD_ADV_K:
            begin
                k_reg     <= next_rdata;
                steps_reg <= steps_reg + 1'b1;
            end
            fch_pkg::CMD_FOUND:
            begin
                hit_reg <= 1'b1;
                res_reg <= k_reg[SW-1:0];
            end
            fch_pkg::CMD_OUT:
            begin
                out_data_reg <= {7'd0, res_reg, hit_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.op        = op_reg;
        status.used_s    = used_reg[slot_reg];
        status.hash_done = (hcnt_reg == hlen_reg);
        status.mod_done  = (mcnt_reg == 6'd32);
        status.k_is_s    = (k_reg == {1'b0, slot_reg});
        status.k_end     = k_reg[LW-1];
        status.steps_end = (steps_reg == LW'(fch_pkg::NUM_SLOTS));
        status.next_is_s = (next_rdata == {1'b0, slot_reg});
        status.match     = used_reg[k_reg[SW-1:0]] && (key_rdata[KW +: NL] == len_reg)
                           && (key_rdata[KW-1:0] == key_reg);
        status.out_free  = !out_vld_reg || m_tready;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

[design/fch_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fch_ctrl
// Sequencer for insert, remove and find over the datapath.
// ----------------------------------------------------------------------------
module fch_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  fch_pkg::status_t status,
    output fch_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISPATCH  = 4'd1;
    localparam logic [3:0] ST_U_WAIT    = 4'd2;
    localparam logic [3:0] ST_HASH      = 4'd3;
    localparam logic [3:0] ST_MOD       = 4'd4;
    localparam logic [3:0] ST_HEAD_WAIT = 4'd5;
    localparam logic [3:0] ST_UL_CHECK  = 4'd6;
    localparam logic [3:0] ST_UL_WAIT   = 4'd7;
    localparam logic [3:0] ST_UL_WALK   = 4'd8;
    localparam logic [3:0] ST_UL_DONE   = 4'd9;
    localparam logic [3:0] ST_INS_WRITE = 4'd10;
    localparam logic [3:0] ST_FIND_STEP = 4'd11;
    localparam logic [3:0] ST_FIND_WAIT = 4'd12;
    localparam logic [3:0] ST_FINISH    = 4'd13;

    localparam logic [1:0] PH_UNLINK = 2'd0;
    localparam logic [1:0] PH_INSERT = 2'd1;
    localparam logic [1:0] PH_FIND   = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_UNLINK;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = fch_pkg::CMD_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd        = fch_pkg::CMD_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (status.used_s && (status.op == fch_pkg::OP_INSERT ||
                                               status.op == fch_pkg::OP_REMOVE))
                begin
                    cmd        = fch_pkg::CMD_RD_SLOT;
                    phase_next = PH_UNLINK;
                    state_next = ST_U_WAIT;
                end
                else if (status.op == fch_pkg::OP_INSERT)
                begin
                    cmd        = fch_pkg::CMD_HASH_REQ;
                    phase_next = PH_INSERT;
                    state_next = ST_HASH;
                end
                else if (status.op == fch_pkg::OP_FIND)
                begin
                    cmd        = fch_pkg::CMD_HASH_REQ;
                    phase_next = PH_FIND;
                    state_next = ST_HASH;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_U_WAIT:
            begin
                cmd        = fch_pkg::CMD_HASH_STORED;
                state_next = ST_HASH;
            end
            ST_HASH:
            begin
                if (status.hash_done)
                begin
                    cmd        = fch_pkg::CMD_MOD_START;
                    state_next = ST_MOD;
                end
                else
                begin
                    cmd = fch_pkg::CMD_HASH_STEP;
                end
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    cmd        = fch_pkg::CMD_RD_HEAD;
                    state_next = ST_HEAD_WAIT;
                end
                else
                begin
                    cmd = fch_pkg::CMD_MOD_STEP;
                end
            end
            ST_HEAD_WAIT:
            begin
                cmd = fch_pkg::CMD_LOAD_K;
                unique case (phase_reg)
                    PH_UNLINK: state_next = ST_UL_CHECK;
                    PH_INSERT: state_next = ST_INS_WRITE;
                    default:   state_next = ST_FIND_STEP;
                endcase
            end
            ST_UL_CHECK:
            begin
                priority if (status.k_is_s)
                begin
                    cmd        = fch_pkg::CMD_HEAD_WR;
                    state_next = ST_UL_DONE;
                end
                else if (status.k_end || status.steps_end)
                begin
                    state_next = ST_UL_DONE;
                end
                else
                begin
                    cmd        = fch_pkg::CMD_RD_K;
                    state_next = ST_UL_WAIT;
                end
            end
            ST_UL_WAIT:
            begin
                if (status.next_is_s)
                begin
                    cmd        = fch_pkg::CMD_NEXT_WR;
                    state_next = ST_UL_DONE;
                end
                else
                begin
                    cmd        = fch_pkg::CMD_ADV_K;
                    state_next = ST_UL_WALK;
                end
            end
            ST_UL_WALK:
            begin
                if (status.k_end || status.steps_end)
                begin
                    state_next = ST_UL_DONE;
                end
                else
                begin
                    cmd        = fch_pkg::CMD_RD_K;
                    state_next = ST_UL_WAIT;
                end
            end
            ST_UL_DONE:
            begin
                if (status.op == fch_pkg::OP_INSERT)
                begin
                    cmd        = fch_pkg::CMD_HASH_REQ;
                    phase_next = PH_INSERT;
                    state_next = ST_HASH;
                end
                else
                begin
                    cmd        = fch_pkg::CMD_CLEAR_SLOT;
                    state_next = ST_FINISH;
                end
            end
            ST_INS_WRITE:
            begin
                cmd        = fch_pkg::CMD_INSERT;
                state_next = ST_FINISH;
            end
            ST_FIND_STEP:
            begin
                if (status.k_end || status.steps_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd        = fch_pkg::CMD_RD_K;
                    state_next = ST_FIND_WAIT;
                end
            end
            ST_FIND_WAIT:
            begin
                if (status.match)
                begin
                    cmd        = fch_pkg::CMD_FOUND;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd        = fch_pkg::CMD_ADV_K;
                    state_next = ST_FIND_STEP;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd        = fch_pkg::CMD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

[design/fch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fch_checker
// Port-level checks of the hash index handshakes.
// ----------------------------------------------------------------------------
module fch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a new result comes out of a busy block and frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready) && s_tready)
        else $error("result without a request in work");

endmodule

bind fnv_chained_hash_index fch_checker u_fch_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
